[src/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and codes of the depth-first maze carver: register indexes,
// event and direction codes, and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // internal width of grid bounds, wide enough for 256 rows or columns
  localparam int unsigned DIMW = 9;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

  localparam logic [1:0] EV_RESTARTED = 2'd0;
  localparam logic [1:0] EV_CARVED    = 2'd1;
  localparam logic [1:0] EV_BACKTRACK = 2'd2;
  localparam logic [1:0] EV_FINISHED  = 2'd3;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_EAST  = 2'd3;

  localparam logic ACT_RESTART = 1'b0;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic start_commit;
    logic emit_finish;
    logic top_latch;
    logic scan_step;
    logic choose;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic clear_last;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

[src/maze_carver_dfs.sv]
// Carve step: the controller runs TOP, SCAN, CHOOSE and COMMIT, and takes no new input beat meanwhile;
// the neighbour scan makes four visited-map reads through one memory read port.
// Restart: a sweep clears the visited map one cell a cycle, then the start cell is committed.
// Step on an empty stack: a finished beat is emitted once the output slot is free.
// Reset restores the register defaults and empties the path stack; the visited
// map is not touched by reset, it is swept by the first restart.
// ----------------------------------------------------------------------------
// maze_carver_dfs
// Randomized depth-first maze carver with an explicit path stack, reporting
// each carved wall, backtrack, restart and finish as one result beat.
// ----------------------------------------------------------------------------
module maze_carver_dfs #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [14:0] random_value
  input  logic [0:0]                     s_axis_tuser,  // [0] action
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] cell_row, [9:5] cell_col, [11:10] carve_dir, [22:12] path_depth
  output logic [23:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser   // [1:0] event_kind
);

  mcd_pkg::cmd_t cmd;
  mcd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcd_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rand_i      (s_axis_tdata[14:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

[src/mcd_ram.sv]
// ----------------------------------------------------------------------------
// mcd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mcd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/mcd_ctrl.sv]
// ----------------------------------------------------------------------------
// mcd_ctrl
// Sequencer of the maze carver: takes an input beat, runs the clearing sweep
// or the neighbour scan, and commits the result once the output slot is free.
// ----------------------------------------------------------------------------
module mcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_ready_o,
  input  mcd_pkg::sts_t sts_i,
  output mcd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_TOP    = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_CHOOSE = 3'd6;
  localparam logic [2:0] S_COMMIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept) begin
          if (in_action_i == mcd_pkg::ACT_RESTART) begin
            state_d = S_CLEAR;
          end else if (sts_i.count_zero) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_TOP;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.out_free) begin
          cmd_o.start_commit = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_finish = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_TOP: begin
        cmd_o.top_latch = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        cmd_o.choose = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_restart_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_action_i == mcd_pkg::ACT_RESTART) |=> (state_q == S_CLEAR))
    else $error("restart beat did not start the clearing sweep");
  a_empty_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_action_i != mcd_pkg::ACT_RESTART && sts_i.count_zero)
    |=> (state_q == S_FINISH))
    else $error("step on empty stack did not go to finish");
  a_commit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && !sts_i.out_free) |=> (state_q == S_COMMIT))
    else $error("commit left while output slot was busy");
`endif

endmodule

[src/mcd_dp.sv]
// ----------------------------------------------------------------------------
// mcd_dp
// Datapath of the maze carver: configuration registers, visited map and path
// stack memories, neighbour scan, direction pick and the output register.
// ----------------------------------------------------------------------------
module mcd_dp #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [14:0]                      rand_i,
  input  mcd_pkg::cmd_t                    cmd_i,
  output mcd_pkg::sts_t                    sts_o,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [23:0]                      m_tdata_o,
  output logic [1:0]                       m_tuser_o
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned DW    = mcd_pkg::DIMW;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    cell_addr = AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  // residue mod 3 by folding base-4 digits
  function automatic logic [1:0] mod3(input logic [14:0] v);
    logic [15:0] vv;
    logic [4:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    vv = {1'b0, v};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 5'(vv[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    case (s3)
      3'd3:    mod3 = 2'd0;
      3'd4:    mod3 = 2'd1;
      default: mod3 = s3[1:0];
    endcase
  endfunction

  // configuration
  logic [5:0] grid_rows_q, grid_cols_q;
  logic [4:0] start_row_q, start_col_q, goal_row_q, goal_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 6'd32;
      grid_cols_q <= 6'd32;
      start_row_q <= 5'd0;
      start_col_q <= 5'd0;
      goal_row_q  <= 5'd31;
      goal_col_q  <= 5'd31;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mcd_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data_i[5:0];
        mcd_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i[5:0];
        mcd_pkg::REG_START_ROW: start_row_q <= cfg_data_i[4:0];
        mcd_pkg::REG_START_COL: start_col_q <= cfg_data_i[4:0];
        mcd_pkg::REG_GOAL_ROW:  goal_row_q  <= cfg_data_i[4:0];
        mcd_pkg::REG_GOAL_COL:  goal_col_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // bounds saturated to 1..MAX
  logic [DW-1:0] rows_lim, cols_lim, sr_w, sc_w;

  always_comb begin
    if (grid_rows_q == 6'd0) begin
      rows_lim = DW'(1);
    end else if (DW'(grid_rows_q) > DW'(MAX_ROWS)) begin
      rows_lim = DW'(MAX_ROWS);
    end else begin
      rows_lim = DW'(grid_rows_q);
    end
    if (grid_cols_q == 6'd0) begin
      cols_lim = DW'(1);
    end else if (DW'(grid_cols_q) > DW'(MAX_COLS)) begin
      cols_lim = DW'(MAX_COLS);
    end else begin
      cols_lim = DW'(grid_cols_q);
    end
    sr_w = (DW'(start_row_q) < rows_lim) ? DW'(start_row_q) : rows_lim - DW'(1);
    sc_w = (DW'(start_col_q) < cols_lim) ? DW'(start_col_q) : cols_lim - DW'(1);
  end

  // working registers
  logic [CNTW-1:0] count_q;
  logic [AW-1:0]   clr_q;
  logic [14:0]     rand_q;
  logic [RW-1:0]   cur_row_q;
  logic [CW-1:0]   cur_col_q;
  logic [2:0]      scan_q;
  logic [3:0]      open_q;
  logic [1:0]      dir_q;
  logic            carve_q;

  logic [RW+CW-1:0] stk_rdata, stk_wdata;
  logic [AW-1:0]    stk_waddr, stk_raddr;
  logic             stk_we;
  logic             vis_rdata, vis_wdata, vis_we;
  logic [AW-1:0]    vis_waddr, vis_raddr;

  // neighbour geometry
  logic [1:0]    nb_dir, cap_dir;
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;
  logic [AW-1:0] nb_addr;
  logic [3:0]    in_grid;
  logic          at_goal;

  assign nb_dir  = cmd_i.scan_step ? scan_q[1:0] : dir_q;
  assign cap_dir = 2'(scan_q - 3'd1);

  always_comb begin
    nb_row = cur_row_q;
    nb_col = cur_col_q;
    case (nb_dir)
      mcd_pkg::DIR_NORTH: nb_row = cur_row_q - RW'(1);
      mcd_pkg::DIR_SOUTH: nb_row = cur_row_q + RW'(1);
      mcd_pkg::DIR_WEST:  nb_col = cur_col_q - CW'(1);
      mcd_pkg::DIR_EAST:  nb_col = cur_col_q + CW'(1);
      default: ;
    endcase
  end

  assign nb_addr = cell_addr(nb_row, nb_col);

  assign in_grid[mcd_pkg::DIR_NORTH] = (cur_row_q != '0);
  assign in_grid[mcd_pkg::DIR_SOUTH] = (DW'(cur_row_q) + DW'(1)) < rows_lim;
  assign in_grid[mcd_pkg::DIR_WEST]  = (cur_col_q != '0);
  assign in_grid[mcd_pkg::DIR_EAST]  = (DW'(cur_col_q) + DW'(1)) < cols_lim;
  assign at_goal = (DW'(cur_row_q) == DW'(goal_row_q)) &&
                   (DW'(cur_col_q) == DW'(goal_col_q));

  // direction pick
  logic [2:0] n_open;
  logic [1:0] k_sel, pick_dir;
  logic [2:0] seen;
  logic       found;

  assign n_open = 3'(open_q[0]) + 3'(open_q[1]) + 3'(open_q[2]) + 3'(open_q[3]);

  always_comb begin
    case (n_open)
      3'd2:    k_sel = {1'b0, rand_q[0]};
      3'd3:    k_sel = mod3(rand_q);
      3'd4:    k_sel = rand_q[1:0];
      default: k_sel = 2'd0;
    endcase
    pick_dir = mcd_pkg::DIR_NORTH;
    seen     = 3'd0;
    found    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (open_q[i] && !found) begin
        if (seen == {1'b0, k_sel}) begin
          pick_dir = 2'(i);
          found    = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  // memory ports
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_q;
    vis_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.start_commit) begin
      vis_we    = 1'b1;
      vis_waddr = cell_addr(RW'(sr_w), CW'(sc_w));
      vis_wdata = 1'b1;
    end else if (cmd_i.commit && carve_q) begin
      vis_we    = 1'b1;
      vis_waddr = nb_addr;
      vis_wdata = 1'b1;
    end
  end

  assign vis_raddr = nb_addr;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = AW'(count_q);
    stk_wdata = {nb_row, nb_col};
    if (cmd_i.start_commit) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {RW'(sr_w), CW'(sc_w)};
    end else if (cmd_i.commit && carve_q) begin
      stk_we = 1'b1;
    end
  end

  assign stk_raddr = AW'(count_q - CNTW'(1));

  mcd_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  mcd_ram #(
    .WIDTH (RW + CW),
    .DEPTH (CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
      scan_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.top_latch) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 3'd1;
      end
      if (cmd_i.start_commit) begin
        count_q <= CNTW'(1);
      end else if (cmd_i.commit) begin
        count_q <= carve_q ? count_q + CNTW'(1) : count_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rand_q <= rand_i;
    end
    if (cmd_i.top_latch) begin
      {cur_row_q, cur_col_q} <= stk_rdata;
      open_q                 <= '0;
    end
    // read data of the previous scan cycle belongs to the direction before
    if (cmd_i.scan_step && scan_q != 3'd0) begin
      open_q[cap_dir] <= in_grid[cap_dir] & ~at_goal & ~vis_rdata;
    end
    if (cmd_i.choose) begin
      dir_q   <= pick_dir;
      carve_q <= (n_open != 3'd0) && (count_q < CNTW'(CELLS));
    end
  end

  // output register
  logic        m_tvalid_q;
  logic [1:0]  o_kind_q, o_dir_q;
  logic [4:0]  o_row_q, o_col_q;
  logic [10:0] o_depth_q;
  logic        emit;

  assign emit = cmd_i.start_commit | cmd_i.emit_finish | cmd_i.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_commit) begin
      o_kind_q  <= mcd_pkg::EV_RESTARTED;
      o_row_q   <= 5'(sr_w);
      o_col_q   <= 5'(sc_w);
      o_dir_q   <= mcd_pkg::DIR_NORTH;
      o_depth_q <= 11'd1;
    end else if (cmd_i.emit_finish) begin
      o_kind_q  <= mcd_pkg::EV_FINISHED;
      o_row_q   <= 5'd0;
      o_col_q   <= 5'd0;
      o_dir_q   <= mcd_pkg::DIR_NORTH;
      o_depth_q <= 11'd0;
    end else if (cmd_i.commit) begin
      o_row_q <= 5'(cur_row_q);
      o_col_q <= 5'(cur_col_q);
      if (carve_q) begin
        o_kind_q  <= mcd_pkg::EV_CARVED;
        o_dir_q   <= dir_q;
        o_depth_q <= 11'(count_q + CNTW'(1));
      end else begin
        o_kind_q  <= mcd_pkg::EV_BACKTRACK;
        o_dir_q   <= mcd_pkg::DIR_NORTH;
        o_depth_q <= 11'(count_q - CNTW'(1));
      end
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {1'b0, o_depth_q, o_dir_q, o_col_q, o_row_q};
  assign m_tuser_o  = o_kind_q;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.clear_last = (clr_q == AW'(CELLS - 1));
  assign sts_o.scan_last  = (scan_q == 3'd4);
  assign sts_o.out_free   = ~m_tvalid_q | m_tready_i;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_tvalid_q || m_tready_i))
    else $error("result written over a beat not yet taken");
  a_carve_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && carve_q) |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("carve did not push the stack");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !carve_q) |-> (count_q != '0))
    else $error("backtrack on empty stack");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CELLS))
    else $error("path depth beyond stack size");
`endif

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth-first maze carver. Restart and step
// commands are streamed in under varying grid settings, a behavioral model of
// the carver predicts every event beat, and the result stream is compared
// field by field against the predictions in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic           ACT_STEP    = ~mcd_pkg::ACT_RESTART;
  localparam logic [1:0]     DIR_NONE    = 2'd0;
  localparam logic [2:0]     REG_SPARE   = 3'd7;
  localparam int unsigned    GRID_CELLS  = 1024;
  localparam int unsigned    CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [1:0]  dir;
    logic [10:0] depth;
  } carve_event_t;

  // behavioral carver plus the queue of events it still waits to see
  class carve_log;
    carve_event_t pending_events[$];
    int unsigned  bad_events;
    logic [5:0]   rows_reg, cols_reg;
    logic [4:0]   start_r, start_c, goal_r, goal_c;
    bit           visited[GRID_CELLS];
    logic [9:0]   path[GRID_CELLS];
    int unsigned  depth;

    function new();
      rows_reg = 6'd32;
      cols_reg = 6'd32;
      start_r = 5'd0;
      start_c = 5'd0;
      goal_r = 5'd31;
      goal_c = 5'd31;
      depth = 0;
      bad_events = 0;
    endfunction

    function int unsigned clamp_dim(logic [5:0] v);
      if (v == 6'd0) return 1;
      return (v > 6'd32) ? 32 : int'(v);
    endfunction

    function void set_reg(logic [2:0] idx, logic [5:0] val);
      case (idx)
        mcd_pkg::REG_GRID_ROWS: rows_reg = val;
        mcd_pkg::REG_GRID_COLS: cols_reg = val;
        mcd_pkg::REG_START_ROW: start_r = val[4:0];
        mcd_pkg::REG_START_COL: start_c = val[4:0];
        mcd_pkg::REG_GOAL_ROW:  goal_r = val[4:0];
        mcd_pkg::REG_GOAL_COL:  goal_c = val[4:0];
        default: ;
      endcase
    endfunction

    function void take_cmd(logic act, logic [14:0] rnd);
      int unsigned  rows, cols, sr, sc, cur, row, col, n, k;
      logic [1:0]   opt_dir[4];
      int unsigned  opt_cell[4];
      carve_event_t ev;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      ev.dir = DIR_NONE;
      if (act == mcd_pkg::ACT_RESTART) begin
        sr = (start_r < rows) ? start_r : rows - 1;
        sc = (start_c < cols) ? start_c : cols - 1;
        foreach (visited[i]) visited[i] = 1'b0;
        cur = sr * 32 + sc;
        visited[cur] = 1'b1;
        path[0] = cur[9:0];
        depth = 1;
        ev.kind = mcd_pkg::EV_RESTARTED;
        ev.row = sr[4:0];
        ev.col = sc[4:0];
      end else if (depth == 0) begin
        ev.kind = mcd_pkg::EV_FINISHED;
        ev.row = 5'd0;
        ev.col = 5'd0;
      end else begin
        cur = path[depth-1];
        row = cur / 32;
        col = cur % 32;
        n = 0;
        // the goal cell is never expanded, only popped
        if (!(row == goal_r && col == goal_c)) begin
          if (row > 0 && !visited[cur-32]) begin
            opt_dir[n] = mcd_pkg::DIR_NORTH; opt_cell[n] = cur - 32; n++;
          end
          if (row + 1 < rows && row + 1 < 32 && !visited[cur+32]) begin
            opt_dir[n] = mcd_pkg::DIR_SOUTH; opt_cell[n] = cur + 32; n++;
          end
          if (col > 0 && !visited[cur-1]) begin
            opt_dir[n] = mcd_pkg::DIR_WEST; opt_cell[n] = cur - 1; n++;
          end
          if (col + 1 < cols && col + 1 < 32 && !visited[cur+1]) begin
            opt_dir[n] = mcd_pkg::DIR_EAST; opt_cell[n] = cur + 1; n++;
          end
        end
        ev.row = row[4:0];
        ev.col = col[4:0];
        if (n > 0 && depth < GRID_CELLS) begin
          k = rnd % n;
          visited[opt_cell[k]] = 1'b1;
          path[depth] = opt_cell[k][9:0];
          depth++;
          ev.kind = mcd_pkg::EV_CARVED;
          ev.dir = opt_dir[k];
        end else begin
          depth--;
          ev.kind = mcd_pkg::EV_BACKTRACK;
        end
      end
      ev.depth = depth[10:0];
      pending_events = {pending_events, ev};
    endfunction

    function void note_diff(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: carve event %s expected %0d actual %0d", $time, field, want, got);
        bad_events++;
      end
    endfunction

    function void match_event(logic [23:0] data, logic [1:0] kind);
      carve_event_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected carve event expected none actual kind %0d data %h",
                 $time, kind, data);
        bad_events++;
        return;
      end
      want = pending_events.pop_front();
      note_diff("kind", want.kind, kind);
      note_diff("row", want.row, data[4:0]);
      note_diff("col", want.col, data[9:5]);
      note_diff("dir", want.dir, data[11:10]);
      note_diff("depth", want.depth, data[22:12]);
    endfunction

    function int unsigned pending();
      return pending_events.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [mcd_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [mcd_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata;
  logic [0:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [23:0]                    m_axis_tdata;
  logic [1:0]                     m_axis_tuser;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;
  carve_log    log = new();

  maze_carver_dfs u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("maze_carver_dfs: mismatch");
      $finish;
    end
  end

  // sample every handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) log.set_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) log.take_cmd(s_axis_tuser[0], s_axis_tdata[14:0]);
      if (m_axis_tvalid && m_axis_tready) log.match_event(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_cmd(logic act, logic [14:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {1'b0, rnd};
    s_axis_tuser = act;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (log.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [5:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_grid(logic [5:0] rows, logic [5:0] cols, logic [5:0] sr,
                              logic [5:0] sc, logic [5:0] gr, logic [5:0] gc);
    drain();
    write_reg(mcd_pkg::REG_GRID_ROWS, rows);
    write_reg(mcd_pkg::REG_GRID_COLS, cols);
    write_reg(mcd_pkg::REG_START_ROW, sr);
    write_reg(mcd_pkg::REG_START_COL, sc);
    write_reg(mcd_pkg::REG_GOAL_ROW, gr);
    write_reg(mcd_pkg::REG_GOAL_COL, gc);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [5:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 6'($urandom_range(1, 8));
    if (r < 90) return 6'($urandom_range(9, 32));
    if (r < 95) return 6'd0;
    return 6'($urandom_range(33, 63));
  endfunction

  function automatic logic [5:0] pick_pos(logic [5:0] dim, int unsigned inside_pct);
    int unsigned span;
    span = (dim == 6'd0) ? 1 : (dim > 6'd32) ? 32 : int'(dim);
    if ($urandom_range(99) < inside_pct) return 6'($urandom_range(0, span - 1));
    return 6'($urandom_range(63));
  endfunction

  initial begin
    logic [5:0] rows, cols;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // step before any restart finds the stack empty
    send_cmd(ACT_STEP, 15'h7fff);
    // unused index, then a 3x2 grid walked to completion with start clamped in
    drain();
    write_reg(REG_SPARE, 6'h3f);
    cfg_valid_i = 1'b0;
    program_grid(6'd3, 6'd2, 6'd20, 6'd63, 6'd0, 6'd0);
    send_cmd(mcd_pkg::ACT_RESTART, 15'h0000);
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0: send_cmd(ACT_STEP, 15'h7fff);
        1: send_cmd(ACT_STEP, 15'h0000);
        2: send_cmd(ACT_STEP, 15'h5555);
        default: send_cmd(ACT_STEP, 15'h2aaa);
      endcase
    end
    // sizes below and above range saturate, goal lies off the grid
    program_grid(6'd0, 6'd63, 6'd0, 6'd0, 6'd31, 6'd31);
    send_cmd(mcd_pkg::ACT_RESTART, 15'h1234);
    send_cmd(ACT_STEP, 15'h0001);
    send_cmd(ACT_STEP, 15'h4000);
    program_grid(6'd40, 6'd8, 6'd31, 6'd7, 6'd31, 6'd31);
    send_cmd(mcd_pkg::ACT_RESTART, 15'h0000);
    send_cmd(ACT_STEP, 15'h0002);
    send_cmd(ACT_STEP, 15'h0003);
    // shrink mid-run: the top cell now sits beyond the last row and column
    program_grid(6'd2, 6'd2, 6'd0, 6'd0, 6'd31, 6'd31);
    send_cmd(ACT_STEP, 15'h0000);
    send_cmd(ACT_STEP, 15'h0001);
    send_cmd(ACT_STEP, 15'h7ffe);

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct  = (regime == 0) ? 23 : (regime == 1) ? 78 : 0;
      recv_stall_pct = (regime == 0) ? 78 : (regime == 1) ? 23 : 0;
      for (int phase = 0; phase < 4; phase++) begin
        rows = pick_dim();
        cols = pick_dim();
        program_grid(rows, cols, pick_pos(rows, 80), pick_pos(cols, 80),
                     pick_pos(rows, 70), pick_pos(cols, 70));
        // now and then keep the old walk going under the new bounds
        if ((regime == 0 && phase == 0) || $urandom_range(99) < 80)
          send_cmd(mcd_pkg::ACT_RESTART, 15'($urandom_range(32767)));
        for (int i = 0; i < 33; i++)
          send_cmd(($urandom_range(99) < 4) ? mcd_pkg::ACT_RESTART : ACT_STEP,
                   15'($urandom_range(32767)));
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (log.bad_events == 0) begin
      $display("maze_carver_dfs: match");
    end else begin
      $display("maze_carver_dfs: mismatch");
    end
    $finish;
  end

endmodule
